FILE: hdl/text_mode_terminal_writer_top_defines.svh
// ----------------------------------------------------------------------------
// text mode terminal writer assertion macros
// concurrent assertion shorthands shared by the checker
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_TERMINAL_WRITER_TOP_DEFINES_SVH
`define TEXT_MODE_TERMINAL_WRITER_TOP_DEFINES_SVH

// same-cycle implication
`define TMTW_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tmtw assertion failed");

// next-cycle implication
`define TMTW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tmtw assertion failed");

`endif

FILE: hdl/tmtw_pkg.sv
// ----------------------------------------------------------------------------
// tmtw_pkg
// types and constants of the text mode terminal writer
// ----------------------------------------------------------------------------
`default_nettype none

package tmtw_pkg;

   localparam int OP_W     = 2;
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int COLUMN_W = 7;
   localparam int ROW_W    = 5;
   localparam int CELL_W   = CHAR_W + ATTR_W;
   localparam int POS_W    = COLUMN_W + ROW_W;

   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
   localparam int                TAB_STOP   = 8;

   typedef enum logic [OP_W-1:0] {
      OP_PUT   = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_WRITE,
      ST_READ,
      ST_READ_WAIT,
      ST_SCROLL,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [COLUMN_W-1:0] column;
      logic [ROW_W-1:0]    row;
      logic                write_cell;
      logic                scroll;
   } cursor_step_type;

endpackage

`default_nettype wire

FILE: hdl/tmtw_if.sv
// ----------------------------------------------------------------------------
// tmtw channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface tmtw_req_if;
   logic                             valid;
   logic                             ready;
   logic [tmtw_pkg::OP_W-1:0]        operation;
   logic [tmtw_pkg::CHAR_W-1:0]      char_code;
   logic [tmtw_pkg::ATTR_W-1:0]      cell_attribute;
   logic [tmtw_pkg::COLUMN_W-1:0]    column;
   logic [tmtw_pkg::ROW_W-1:0]       row;

   modport source (output valid, operation, char_code, cell_attribute, column, row,
                   input ready);
   modport sink (input valid, operation, char_code, cell_attribute, column, row,
                 output ready);
endinterface

interface tmtw_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [tmtw_pkg::CELL_W-1:0]      cell_data;
   logic [tmtw_pkg::COLUMN_W-1:0]    cursor_column;
   logic [tmtw_pkg::ROW_W-1:0]       cursor_row;
   logic                             scrolled;
   logic                             bad_position;

   modport source (output valid, cell_data, cursor_column, cursor_row, scrolled,
                   bad_position, input ready);
   modport sink (input valid, cell_data, cursor_column, cursor_row, scrolled,
                 bad_position, output ready);
endinterface

`default_nettype wire

FILE: hdl/tmtw_cursor.sv
// ----------------------------------------------------------------------------
// tmtw_cursor
// cursor movement for one put character transaction
// ----------------------------------------------------------------------------
`default_nettype none

module tmtw_cursor #(
   parameter int SCREEN_WIDTH  = 80,
   parameter int SCREEN_HEIGHT = 25
) (
   input  wire logic [tmtw_pkg::CHAR_W-1:0]   char_code,
   input  wire logic [tmtw_pkg::COLUMN_W-1:0] cursor_column,
   input  wire logic [tmtw_pkg::ROW_W-1:0]    cursor_row,
   output tmtw_pkg::cursor_step_type          step
);

   localparam int COL_EXT_W = tmtw_pkg::COLUMN_W + 1;
   localparam int ROW_EXT_W = tmtw_pkg::ROW_W + 1;

   logic [COL_EXT_W-1:0] tab_column;
   logic [COL_EXT_W-1:0] inc_column;
   logic [ROW_EXT_W-1:0] inc_row;
   logic                 row_wrap;
   logic                 printable;

   always_comb begin
      tab_column = (COL_EXT_W'(cursor_column) + COL_EXT_W'(tmtw_pkg::TAB_STOP))
                   & ~COL_EXT_W'(tmtw_pkg::TAB_STOP - 1);
      inc_column = COL_EXT_W'(cursor_column) + COL_EXT_W'(1);
      inc_row    = ROW_EXT_W'(cursor_row) + ROW_EXT_W'(1);
      row_wrap   = (inc_row >= ROW_EXT_W'(SCREEN_HEIGHT));
      printable  = !char_code[tmtw_pkg::CHAR_W-1] && (char_code >= tmtw_pkg::CHAR_SPACE);
   end

   always_comb begin
      step.column     = cursor_column;
      step.row        = cursor_row;
      step.write_cell = 1'b0;
      step.scroll     = 1'b0;
      priority if (char_code == tmtw_pkg::CHAR_LF) begin
         step.column = '0;
         step.row    = row_wrap ? cursor_row : inc_row[tmtw_pkg::ROW_W-1:0];
         step.scroll = row_wrap;
      end else if (char_code == tmtw_pkg::CHAR_CR) begin
         step.column = '0;
      end else if (char_code == tmtw_pkg::CHAR_TAB) begin
         if (tab_column >= COL_EXT_W'(SCREEN_WIDTH)) begin
            step.column = '0;
            step.row    = row_wrap ? cursor_row : inc_row[tmtw_pkg::ROW_W-1:0];
            step.scroll = row_wrap;
         end else begin
            step.column = tab_column[tmtw_pkg::COLUMN_W-1:0];
         end
      end else if (printable) begin
         step.write_cell = 1'b1;
         if (inc_column >= COL_EXT_W'(SCREEN_WIDTH)) begin
            step.column = '0;
            step.row    = row_wrap ? cursor_row : inc_row[tmtw_pkg::ROW_W-1:0];
            step.scroll = row_wrap;
         end else begin
            step.column = inc_column[tmtw_pkg::COLUMN_W-1:0];
         end
      end else begin
         step.write_cell = 1'b0;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/text_mode_terminal_writer_top.sv
// ----------------------------------------------------------------------------
// text_mode_terminal_writer_top
// text mode terminal: screen memory, cursor, scroll and clear sequencing
// ----------------------------------------------------------------------------
// The screen lives in one simple dual-port memory of SCREEN_WIDTH *
// SCREEN_HEIGHT 16-bit cells (one write and one registered read a cycle).
// After reset a clearing pass writes every cell, one per cycle, so no
// transaction is accepted until the pass ends; the attribute register may
// be written meanwhile. Transactions are handled one at a time: after
// acceptance a printable put character or a write cell passes the decode,
// write and done states, a read cell decode, read, read wait and done, and
// any other put character, a clear command or a write or read cell at a bad
// position decode and done, plus the memory sweeps below and any wait for the
// output register. Clear sweeps every cell, one per cycle; a scroll copies
// each cell one line up through the memory's read and write ports in
// parallel and then blanks the bottom line. A new transaction is taken
// while the previous response still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module text_mode_terminal_writer_top #(
   parameter int SCREEN_WIDTH  = 80,
   parameter int SCREEN_HEIGHT = 25
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   tmtw_req_if.sink                           req_chan,
   tmtw_rsp_if.source                         rsp_chan,
   input  wire logic                          csr_write_enable,
   input  wire logic [tmtw_pkg::ATTR_W-1:0]   csr_write_data
);

   localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int SCAN_W     = $clog2(CELL_COUNT + 1);

   localparam int COLUMN_W = tmtw_pkg::COLUMN_W;
   localparam int ROW_W    = tmtw_pkg::ROW_W;
   localparam int CELL_W   = tmtw_pkg::CELL_W;
   localparam int POS_W    = tmtw_pkg::POS_W;

   // memory
   logic [CELL_W-1:0] screen_mem [CELL_COUNT];
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   logic [CELL_W-1:0] mem_rd_data_ff;

   // control
   tmtw_pkg::state_type state_ff, state_in;
   logic [SCAN_W-1:0]   scan_ff, scan_in;
   logic                copy_valid_ff, copy_valid_in;
   logic [ADDR_W-1:0]   copy_addr_ff, copy_addr_in;
   logic [COLUMN_W-1:0] cursor_col_ff, cursor_col_in;
   logic [ROW_W-1:0]    cursor_row_ff, cursor_row_in;
   logic [tmtw_pkg::ATTR_W-1:0] text_attr_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   // transaction payload
   tmtw_pkg::op_type              item_op_ff;
   logic [tmtw_pkg::CHAR_W-1:0]   item_char_ff;
   logic [tmtw_pkg::ATTR_W-1:0]   item_attr_ff;
   logic [COLUMN_W-1:0]           item_col_ff;
   logic [ROW_W-1:0]              item_row_ff;
   logic [ADDR_W-1:0]             idx_ff, idx_in;
   logic                          scroll_ff, scroll_in;
   logic                          bad_ff, bad_in;
   logic [CELL_W-1:0]             res_data_ff, res_data_in;

   // response register
   logic [CELL_W-1:0]   rsp_data_ff;
   logic [COLUMN_W-1:0] rsp_col_ff;
   logic [ROW_W-1:0]    rsp_row_ff;
   logic                rsp_scrolled_ff;
   logic                rsp_bad_ff;

   logic                      req_accept;
   logic                      rsp_load;
   logic                      bad_pos;
   logic                      is_put;
   logic [ROW_W-1:0]          mul_row;
   logic [COLUMN_W-1:0]       mul_col;
   logic [POS_W-1:0]          pos_index;
   logic                      scan_last;
   logic                      scan_active;
   tmtw_pkg::cursor_step_type cursor_step;

   tmtw_cursor #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_cursor (
      .char_code     (item_char_ff),
      .cursor_column (cursor_col_ff),
      .cursor_row    (cursor_row_ff),
      .step          (cursor_step)
   );

   assign req_chan.ready = (state_ff == tmtw_pkg::ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.cell_data     = rsp_data_ff;
   assign rsp_chan.cursor_column = rsp_col_ff;
   assign rsp_chan.cursor_row    = rsp_row_ff;
   assign rsp_chan.scrolled      = rsp_scrolled_ff;
   assign rsp_chan.bad_position  = rsp_bad_ff;

   always_comb begin
      is_put      = (item_op_ff == tmtw_pkg::OP_PUT);
      bad_pos     = ((item_op_ff == tmtw_pkg::OP_WRITE) || (item_op_ff == tmtw_pkg::OP_READ))
                    && ((32'(item_col_ff) >= SCREEN_WIDTH)
                        || (32'(item_row_ff) >= SCREEN_HEIGHT));
      mul_row     = is_put ? cursor_row_ff : item_row_ff;
      mul_col     = is_put ? cursor_col_ff : item_col_ff;
      pos_index   = POS_W'(mul_row * SCREEN_WIDTH) + POS_W'(mul_col);
      scan_last   = (scan_ff == SCAN_W'(CELL_COUNT - 1));
      scan_active = (scan_ff < SCAN_W'(CELL_COUNT));
      rsp_load    = (state_ff == tmtw_pkg::ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tmtw_pkg::ST_INIT: begin
            if (scan_last) state_in = tmtw_pkg::ST_IDLE;
         end
         tmtw_pkg::ST_IDLE: begin
            if (req_accept) state_in = tmtw_pkg::ST_DECODE;
         end
         tmtw_pkg::ST_DECODE: begin
            unique case (item_op_ff)
               tmtw_pkg::OP_PUT: begin
                  priority if (cursor_step.write_cell) state_in = tmtw_pkg::ST_WRITE;
                  else if (cursor_step.scroll)         state_in = tmtw_pkg::ST_SCROLL;
                  else                                 state_in = tmtw_pkg::ST_DONE;
               end
               tmtw_pkg::OP_WRITE: state_in = bad_pos ? tmtw_pkg::ST_DONE : tmtw_pkg::ST_WRITE;
               tmtw_pkg::OP_READ:  state_in = bad_pos ? tmtw_pkg::ST_DONE : tmtw_pkg::ST_READ;
               tmtw_pkg::OP_CLEAR: state_in = tmtw_pkg::ST_FILL;
               default:            state_in = tmtw_pkg::ST_DONE;
            endcase
         end
         tmtw_pkg::ST_WRITE: begin
            state_in = scroll_ff ? tmtw_pkg::ST_SCROLL : tmtw_pkg::ST_DONE;
         end
         tmtw_pkg::ST_READ:      state_in = tmtw_pkg::ST_READ_WAIT;
         tmtw_pkg::ST_READ_WAIT: state_in = tmtw_pkg::ST_DONE;
         tmtw_pkg::ST_SCROLL: begin
            if (!scan_active) state_in = tmtw_pkg::ST_FILL;
         end
         tmtw_pkg::ST_FILL: begin
            if (scan_last) state_in = tmtw_pkg::ST_DONE;
         end
         tmtw_pkg::ST_DONE: begin
            if (rsp_load) state_in = tmtw_pkg::ST_IDLE;
         end
         default: state_in = tmtw_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = {text_attr_ff, tmtw_pkg::CHAR_SPACE};
      mem_re        = 1'b0;
      mem_raddr     = idx_ff;
      scan_in       = scan_ff;
      copy_valid_in = 1'b0;
      copy_addr_in  = copy_addr_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      idx_in        = idx_ff;
      scroll_in     = scroll_ff;
      bad_in        = bad_ff;
      res_data_in   = res_data_ff;
      rsp_valid_in  = rsp_valid_ff;

      unique case (state_ff)
         tmtw_pkg::ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = scan_ff[ADDR_W-1:0];
            mem_wdata = {tmtw_pkg::RESET_ATTR, tmtw_pkg::CHAR_SPACE};
            scan_in   = scan_ff + SCAN_W'(1);
         end
         tmtw_pkg::ST_DECODE: begin
            idx_in      = pos_index[ADDR_W-1:0];
            bad_in      = bad_pos;
            res_data_in = '0;
            scroll_in   = 1'b0;
            scan_in     = SCAN_W'(SCREEN_WIDTH);
            unique case (item_op_ff)
               tmtw_pkg::OP_PUT: begin
                  cursor_col_in = cursor_step.column;
                  cursor_row_in = cursor_step.row;
                  scroll_in     = cursor_step.scroll;
               end
               tmtw_pkg::OP_CLEAR: begin
                  cursor_col_in = '0;
                  cursor_row_in = '0;
                  scan_in       = '0;
               end
               default: begin
                  scroll_in = 1'b0;
               end
            endcase
         end
         tmtw_pkg::ST_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = is_put ? {text_attr_ff, item_char_ff} : {item_attr_ff, item_char_ff};
         end
         tmtw_pkg::ST_READ: begin
            mem_re    = 1'b1;
            mem_raddr = idx_ff;
         end
         tmtw_pkg::ST_READ_WAIT: begin
            res_data_in = mem_rd_data_ff;
         end
         tmtw_pkg::ST_SCROLL: begin
            if (scan_active) begin
               mem_re        = 1'b1;
               mem_raddr     = scan_ff[ADDR_W-1:0];
               copy_valid_in = 1'b1;
               copy_addr_in  = ADDR_W'(scan_ff - SCAN_W'(SCREEN_WIDTH));
               scan_in       = scan_ff + SCAN_W'(1);
            end else begin
               scan_in = SCAN_W'(CELL_COUNT - SCREEN_WIDTH);
            end
         end
         tmtw_pkg::ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = scan_ff[ADDR_W-1:0];
            mem_wdata = {text_attr_ff, tmtw_pkg::CHAR_SPACE};
            scan_in   = scan_ff + SCAN_W'(1);
         end
         default: begin
            mem_re = 1'b0;
         end
      endcase

      // pending line copy, written in the cycle after its read
      if (copy_valid_ff) begin
         mem_we    = 1'b1;
         mem_waddr = copy_addr_ff;
         mem_wdata = mem_rd_data_ff;
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rd_data_ff <= screen_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tmtw_pkg::ST_INIT;
         scan_ff       <= '0;
         copy_valid_ff <= 1'b0;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         text_attr_ff  <= tmtw_pkg::RESET_ATTR;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         copy_valid_ff <= copy_valid_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_enable) begin
            text_attr_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      copy_addr_ff <= copy_addr_in;
      idx_ff       <= idx_in;
      scroll_ff    <= scroll_in;
      bad_ff       <= bad_in;
      res_data_ff  <= res_data_in;
      if (req_accept) begin
         item_op_ff   <= tmtw_pkg::op_type'(req_chan.operation);
         item_char_ff <= req_chan.char_code;
         item_attr_ff <= req_chan.cell_attribute;
         item_col_ff  <= req_chan.column;
         item_row_ff  <= req_chan.row;
      end
      if (rsp_load) begin
         rsp_data_ff     <= res_data_ff;
         rsp_col_ff      <= cursor_col_ff;
         rsp_row_ff      <= cursor_row_ff;
         rsp_scrolled_ff <= scroll_ff;
         rsp_bad_ff      <= bad_ff;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/tmtw_checker.sv
// ----------------------------------------------------------------------------
// tmtw_checker
// port-level assertions for the text mode terminal writer
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_mode_terminal_writer_top_defines.svh"

module tmtw_checker #(
   parameter int SCREEN_WIDTH  = 80,
   parameter int SCREEN_HEIGHT = 25
) (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [tmtw_pkg::CELL_W-1:0]       rsp_cell_data,
   input wire logic [tmtw_pkg::COLUMN_W-1:0]     rsp_cursor_column,
   input wire logic [tmtw_pkg::ROW_W-1:0]        rsp_cursor_row,
   input wire logic                              rsp_scrolled,
   input wire logic                              rsp_bad_position
);

   `TMTW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   `TMTW_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   `TMTW_ASSERT_IMPLIES(a_cursor_on_screen, clock, reset, rsp_valid, (rsp_cursor_column < SCREEN_WIDTH) && (rsp_cursor_row < SCREEN_HEIGHT))

   `TMTW_ASSERT_IMPLIES(a_scroll_cursor, clock, reset, rsp_valid && rsp_scrolled, (rsp_cursor_column == 0) && (rsp_cursor_row == SCREEN_HEIGHT - 1))

   `TMTW_ASSERT_IMPLIES(a_bad_position_quiet, clock, reset, rsp_valid && rsp_bad_position, (rsp_cell_data == 0) && !rsp_scrolled)

endmodule

bind text_mode_terminal_writer_top tmtw_checker #(
   .SCREEN_WIDTH  (SCREEN_WIDTH),
   .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tmtw_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_cell_data     (rsp_chan.cell_data),
   .rsp_cursor_column (rsp_chan.cursor_column),
   .rsp_cursor_row    (rsp_chan.cursor_row),
   .rsp_scrolled      (rsp_chan.scrolled),
   .rsp_bad_position  (rsp_chan.bad_position)
);

`default_nettype wire
